### rtl/core/scs_pkg.sv
`default_nettype none

package scs_pkg;

    // sizing
    localparam int KEY_BITS  = 16;
    localparam int MAX_ITEMS = 1024;
    localparam int KEY_SPAN  = 1 << KEY_BITS;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int IN_KEY_W  = 16;
    localparam int VAL_W     = 64;

    // request kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    // result status codes
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    typedef logic [KEY_BITS-1:0] key_t;

    typedef struct packed {
        logic                kind;
        logic [IN_KEY_W-1:0] item_key;
        logic [VAL_W-1:0]    item_value;
    } in_item_t;

    typedef struct packed {
        logic [IN_KEY_W-1:0] out_key;
        logic [VAL_W-1:0]    out_value;
        logic                is_last;
        logic                status;
        logic                overflowed;
    } out_item_t;

    // count table entry: set mark plus count or running sum
    typedef struct packed {
        logic             epoch;
        logic [CNT_W-1:0] cnt;
    } cnt_entry_t;

    // stored key/value pair
    typedef struct packed {
        key_t             key;
        logic [VAL_W-1:0] value;
    } pair_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD_WR,
        ST_PREFIX,
        ST_PLACE_RD,
        ST_PLACE_CNT,
        ST_PLACE_WR,
        ST_DRAIN_ISSUE,
        ST_DRAIN_OUT
    } state_t;

    // wrap a request key to the table index width
    function automatic key_t to_key(input logic [IN_KEY_W-1:0] k);
        key_t r;
        r = '0;
        for (int b = 0; b < KEY_BITS; b++) begin
            if (b < IN_KEY_W) r[b] = k[b];
        end
        return r;
    endfunction

    // widen or cut a table key back to the result field width
    function automatic logic [IN_KEY_W-1:0] from_key(input key_t k);
        logic [IN_KEY_W-1:0] r;
        r = '0;
        for (int b = 0; b < IN_KEY_W; b++) begin
            if (b < KEY_BITS) r[b] = k[b];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/stable_counting_sort.sv
`default_nettype none

// Stable counting sort of key/value pairs. A load request (kind 0) stores the
// pair, and its key count is read, incremented and written back in the count
// table memory; a load that arrives while a set is draining is ignored. A drain
// request (kind 1) returns the next pair in ascending key order, equal keys in
// load order, through the registered read of the sorted-pair memory. The first
// drain of a set first walks the whole count table once to build running sums
// (one read-modify-write per cycle) and then places every stored pair from
// last to first (through PLACE_RD, PLACE_CNT and PLACE_WR, bound by the
// dependent read of the count table); its result then passes DRAIN_ISSUE and
// DRAIN_OUT. A drain with no pairs loaded returns status 1 at once. Loads
// past MAX_ITEMS are dropped and flag overflowed on every drain of the set.
// After reset the block clears the count table, one entry per cycle, over all
// 2^KEY_BITS entries (65536 as built) before it takes its first request; sets
// after the first need no clearing because each entry carries a set mark.
module stable_counting_sort (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire scs_pkg::in_item_t   in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output scs_pkg::out_item_t       out_data
);

    import scs_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] loaded_reg, loaded_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic             drain_reg, drain_next;
    logic             drop_reg, drop_next;
    logic             epoch_reg, epoch_next;
    logic [KEY_BITS:0] scan_reg, scan_next;
    logic [CNT_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    key_t             key_reg, key_next;
    logic [VAL_W-1:0] val_reg, val_next;
    out_item_t        out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    logic             cnt_we;
    key_t             cnt_waddr, cnt_raddr;
    cnt_entry_t       cnt_wdata, cnt_rdata;
    logic             ld_we;
    logic [IDX_W-1:0] ld_waddr, ld_raddr;
    pair_t            ld_wdata, ld_rdata;
    logic             so_we;
    logic [IDX_W-1:0] so_waddr, so_raddr;
    pair_t            so_wdata, so_rdata;

    logic             accept;
    logic [CNT_W-1:0] cnt_eff;
    logic [CNT_W-1:0] idx_m1;
    logic [KEY_BITS:0] scan_m1;
    logic [CNT_W-1:0] sum_new;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] ptr_inc;
    logic             last;

    // count table, load-order pairs, sorted pairs
    scs_ram #(.WIDTH($bits(cnt_entry_t)), .DEPTH(KEY_SPAN)) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    scs_ram #(.WIDTH($bits(pair_t)), .DEPTH(MAX_ITEMS)) u_load_ram (
        .clk   (clk),
        .we    (ld_we),
        .waddr (ld_waddr),
        .wdata (ld_wdata),
        .raddr (ld_raddr),
        .rdata (ld_rdata)
    );

    scs_ram #(.WIDTH($bits(pair_t)), .DEPTH(MAX_ITEMS)) u_sort_ram (
        .clk   (clk),
        .we    (so_we),
        .waddr (so_waddr),
        .wdata (so_wdata),
        .raddr (so_raddr),
        .rdata (so_rdata)
    );

    // entries from an earlier set read as zero
    assign cnt_eff = (cnt_rdata.epoch == epoch_reg) ? cnt_rdata.cnt : '0;
    assign idx_m1  = idx_reg - CNT_W'(1);
    assign scan_m1 = scan_reg - (KEY_BITS+1)'(1);
    assign sum_new = sum_reg + cnt_eff;
    assign pos     = cnt_eff - CNT_W'(1);
    assign ptr_inc = CNT_W'(ptr_reg) + CNT_W'(1);
    assign last    = (ptr_inc == loaded_reg);

    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // state register and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            loaded_reg    <= '0;
            ptr_reg       <= '0;
            drain_reg     <= 1'b0;
            drop_reg      <= 1'b0;
            epoch_reg     <= 1'b0;
            scan_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            loaded_reg    <= loaded_next;
            ptr_reg       <= ptr_next;
            drain_reg     <= drain_next;
            drop_reg      <= drop_next;
            epoch_reg     <= epoch_next;
            scan_reg      <= scan_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        key_reg <= key_next;
        val_reg <= val_next;
        out_reg <= out_next;
    end

    // next state, memory ports and result
    always_comb
    begin
        state_next     = state_reg;
        loaded_next    = loaded_reg;
        ptr_next       = ptr_reg;
        drain_next     = drain_reg;
        drop_next      = drop_reg;
        epoch_next     = epoch_reg;
        scan_next      = scan_reg;
        sum_next       = sum_reg;
        idx_next       = idx_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        cnt_we    = 1'b0;
        cnt_waddr = key_reg;
        cnt_wdata = '{epoch: epoch_reg, cnt: '0};
        cnt_raddr = to_key(in_data.item_key);
        ld_we     = 1'b0;
        ld_waddr  = loaded_reg[IDX_W-1:0];
        ld_wdata  = '{key: to_key(in_data.item_key), value: in_data.item_value};
        ld_raddr  = idx_m1[IDX_W-1:0];
        so_we     = 1'b0;
        so_waddr  = pos[IDX_W-1:0];
        so_wdata  = '{key: key_reg, value: val_reg};
        so_raddr  = ptr_reg;

        // result taken downstream
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            // zero the count table after reset
            ST_CLEAR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = scan_reg[KEY_BITS-1:0];
                cnt_wdata = '{epoch: 1'b0, cnt: '0};
                scan_next = scan_reg + (KEY_BITS+1)'(1);
                if (&scan_reg[KEY_BITS-1:0])
                begin
                    scan_next  = '0;
                    state_next = ST_IDLE;
                end
            end

            // take a request
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.kind == KIND_LOAD)
                    begin
                        if (!drain_reg)
                        begin
                            if (loaded_reg >= CNT_W'(MAX_ITEMS))
                            begin
                                drop_next = 1'b1;
                            end
                            else
                            begin
                                ld_we       = 1'b1;
                                key_next    = to_key(in_data.item_key);
                                loaded_next = loaded_reg + CNT_W'(1);
                                state_next  = ST_LOAD_WR;
                            end
                        end
                    end
                    else if (loaded_reg == '0)
                    begin
                        out_next = '{out_key: '0, out_value: '0, is_last: 1'b0,
                                     status: STATUS_EMPTY, overflowed: drop_reg};
                        out_valid_next = 1'b1;
                        drop_next      = 1'b0;
                        drain_next     = 1'b0;
                        ptr_next       = '0;
                    end
                    else if (!drain_reg)
                    begin
                        drain_next = 1'b1;
                        ptr_next   = '0;
                        scan_next  = '0;
                        sum_next   = '0;
                        state_next = ST_PREFIX;
                    end
                    else
                    begin
                        state_next = ST_DRAIN_OUT;
                    end
                end
            end

            // count increment write-back
            ST_LOAD_WR:
            begin
                cnt_we     = 1'b1;
                cnt_wdata  = '{epoch: epoch_reg, cnt: cnt_eff + CNT_W'(1)};
                state_next = ST_IDLE;
            end

            // running sums: read entry k while writing entry k-1
            ST_PREFIX:
            begin
                cnt_raddr = scan_reg[KEY_BITS-1:0];
                if (scan_reg != '0)
                begin
                    cnt_we    = 1'b1;
                    cnt_waddr = scan_m1[KEY_BITS-1:0];
                    cnt_wdata = '{epoch: epoch_reg, cnt: sum_new};
                    sum_next  = sum_new;
                end
                scan_next = scan_reg + (KEY_BITS+1)'(1);
                if (scan_reg[KEY_BITS])
                begin
                    scan_next  = '0;
                    idx_next   = loaded_reg;
                    state_next = ST_PLACE_RD;
                end
            end

            // placement, last loaded pair first
            ST_PLACE_RD:
            begin
                state_next = ST_PLACE_CNT;
            end

            ST_PLACE_CNT:
            begin
                cnt_raddr  = ld_rdata.key;
                key_next   = ld_rdata.key;
                val_next   = ld_rdata.value;
                state_next = ST_PLACE_WR;
            end

            ST_PLACE_WR:
            begin
                cnt_we    = 1'b1;
                cnt_wdata = '{epoch: epoch_reg, cnt: pos};
                so_we     = 1'b1;
                idx_next  = idx_m1;
                if (idx_reg == CNT_W'(1))
                begin
                    state_next = ST_DRAIN_ISSUE;
                end
                else
                begin
                    state_next = ST_PLACE_RD;
                end
            end

            // read the first sorted pair
            ST_DRAIN_ISSUE:
            begin
                state_next = ST_DRAIN_OUT;
            end

            // return a sorted pair, close the set on the last one
            ST_DRAIN_OUT:
            begin
                out_next = '{out_key: from_key(so_rdata.key), out_value: so_rdata.value,
                             is_last: last, status: STATUS_OK, overflowed: drop_reg};
                out_valid_next = 1'b1;
                if (last)
                begin
                    loaded_next = '0;
                    ptr_next    = '0;
                    drop_next   = 1'b0;
                    drain_next  = 1'b0;
                    epoch_next  = ~epoch_reg;
                end
                else
                begin
                    ptr_next = ptr_inc[IDX_W-1:0];
                end
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // checks
    a_loaded_bound: assert property (@(posedge clk) disable iff (!rst_n)
        loaded_reg <= CNT_W'(MAX_ITEMS))
        else $error("stored pair count exceeds capacity");

    a_ptr_in_set: assert property (@(posedge clk) disable iff (!rst_n)
        drain_reg |-> (CNT_W'(ptr_reg) < loaded_reg))
        else $error("drain position beyond stored pairs");

    a_place_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PLACE_WR) |-> (cnt_eff != '0))
        else $error("placement found an empty running sum");

    a_set_end: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DRAIN_OUT) && last) |=> ((loaded_reg == '0) && !drain_reg))
        else $error("set not closed after final pair");

endmodule

`default_nettype wire

### rtl/core/scs_ram.sv
`default_nettype none

module scs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### tb/tb_stable_counting_sort.sv
`timescale 1ns / 100ps

module tb_stable_counting_sort;

    import scs_pkg::*;

    // longest quiet stretch: table clear or prefix pass plus placement, with stalls
    localparam int WATCHDOG_LIMIT = 300_000;
    localparam int DRAIN_OUT_WAIT = 50;
    localparam int LONG_HOLD      = 400;
    localparam int PART_DRAINS    = 60;

    typedef struct {
        in_item_t req;
        bit       settle;
    } staged_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    // requests waiting to be offered, results still owed by the block
    staged_t   pending[$];
    out_item_t awaited[$];

    // shadow of the sorter: pairs kept in stable key order
    pair_t     ordered[$];
    int        next_pos;
    bit        draining;
    bit        dropped;

    bit        in_taken;
    int        results_seen;
    int        errors;
    int        idle_cycles;
    int        send_gap;
    int        send_calm;
    int        stall_left;
    int        recv_calm;
    int        hold_left;
    int        hold_mark = 100;
    out_item_t want;

    stable_counting_sort dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #1 clk = ~clk;

    // idle length: mostly none or short, now and then long
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic string show(input out_item_t r);
        return $sformatf("key=%h value=%h last=%b status=%b ovf=%b",
                         r.out_key, r.out_value, r.is_last, r.status, r.overflowed);
    endfunction

    // expected behavior of one accepted request
    task automatic sort_predict(input in_item_t req);
        key_t      k;
        int        pos;
        pair_t     p;
        out_item_t res;
        k = key_t'(req.item_key);
        if (req.kind == KIND_LOAD) begin
            if (!draining) begin
                if (ordered.size() >= MAX_ITEMS) begin
                    dropped = 1'b1;
                end else begin
                    // equal keys go after the ones already held
                    pos = ordered.size();
                    while (pos > 0 && ordered[pos-1].key > k) pos--;
                    p.key   = k;
                    p.value = req.item_value;
                    ordered.insert(pos, p);
                end
            end
        end else begin
            res = '0;
            res.overflowed = dropped;
            if (ordered.size() == 0) begin
                res.status = STATUS_EMPTY;
                dropped    = 1'b0;
                draining   = 1'b0;
                next_pos   = 0;
            end else begin
                draining      = 1'b1;
                res.status    = STATUS_OK;
                res.out_key   = IN_KEY_W'(ordered[next_pos].key);
                res.out_value = ordered[next_pos].value;
                res.is_last   = (next_pos + 1 == ordered.size());
                if (res.is_last) begin
                    ordered.delete();
                    next_pos = 0;
                    dropped  = 1'b0;
                    draining = 1'b0;
                end else begin
                    next_pos++;
                end
            end
            awaited.push_back(res);
        end
    endtask

    task automatic plan_load(input logic [IN_KEY_W-1:0] k, input logic [VAL_W-1:0] v,
                             input bit settle);
        staged_t s;
        s.req.kind       = KIND_LOAD;
        s.req.item_key   = k;
        s.req.item_value = v;
        s.settle         = settle;
        pending.push_back(s);
    endtask

    task automatic plan_drain();
        staged_t s;
        s.req.kind       = KIND_DRAIN;
        s.req.item_key   = IN_KEY_W'($urandom);
        s.req.item_value = {$urandom, $urandom};
        s.settle         = 1'b0;
        pending.push_back(s);
    endtask

    // one set: loads with keys of the given style, then up to drain_cap drains, sometimes one extra, with noise
    task automatic plan_set(input int loads, input int key_style, input bit settle,
                            input int drain_cap);
        int                  i;
        int                  drains;
        int                  r;
        logic [IN_KEY_W-1:0] k;
        logic [VAL_W-1:0]    v;
        drains = (loads > MAX_ITEMS) ? MAX_ITEMS : loads;
        if (drains > drain_cap) drains = drain_cap;
        for (i = 0; i < loads; i++) begin
            case (key_style)
                0: k = IN_KEY_W'($urandom_range(0, 65535));
                1: k = IN_KEY_W'($urandom_range(0, 7));
                2: begin
                    r = $urandom_range(0, 3);
                    k = (r == 0) ? '0 : (r == 1) ? IN_KEY_W'(1) : (r == 2) ? '1 :
                        ~IN_KEY_W'(1);
                end
                default: k = IN_KEY_W'($urandom) & 16'hF00F;
            endcase
            r = $urandom_range(0, 39);
            v = (r == 0) ? '0 : (r == 1) ? '1 : {$urandom, $urandom};
            plan_load(k, v, settle && i == 0);
        end
        for (i = 0; i < drains; i++) begin
            // load slipped in mid-drain, must be ignored
            if (i > 0 && $urandom_range(0, 19) == 0)
                plan_load(IN_KEY_W'($urandom), {$urandom, $urandom}, 1'b0);
            plan_drain();
        end
        if ($urandom_range(0, 3) == 0) plan_drain();
    endtask

    // stimulus, reset and end of run
    initial begin
        int s;
        // empty drain, then a set with extreme and tied keys
        plan_drain();
        plan_load('1, '1, 1'b0);
        plan_load('0, '0, 1'b0);
        plan_load(16'h0005, 64'h1, 1'b0);
        plan_load(16'h0005, 64'h2, 1'b0);
        plan_load('0, 64'hA5A5_A5A5_A5A5_A5A5, 1'b0);
        plan_load('1, 64'h5A5A_5A5A_5A5A_5A5A, 1'b0);
        plan_drain();
        plan_load(16'h0003, 64'hDEAD_BEEF_0000_0001, 1'b0);
        repeat (5) plan_drain();
        plan_drain();
        // single-pair set, first drain is also the last
        plan_load(16'h8001, 64'h8000_0000_0000_0001, 1'b1);
        plan_drain();

        // random sets, then one past capacity that is drained only in part
        for (s = 0; s < 3; s++) begin
            plan_set($urandom_range(20, 60), s, s == 0 || $urandom_range(0, 1),
                     MAX_ITEMS);
        end
        plan_set(MAX_ITEMS + $urandom_range(1, 12), 3, 1'b1, PART_DRAINS);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (pending.size() == 0 && !in_valid);
        wait (awaited.size() == 0);
        repeat (DRAIN_OUT_WAIT) @(posedge clk);
        if (errors == 0)
            $display("[stable_counting_sort] OK");
        else
            $display("[stable_counting_sort] ERROR");
        $finish;
    end

    // request driver
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !in_taken) begin
            // request still offered
        end else if (send_gap > 0) begin
            in_valid <= 1'b0;
            send_gap--;
        end else if (pending.size() != 0 && !(pending[0].settle && awaited.size() != 0)) begin
            in_data  <= pending[0].req;
            in_valid <= 1'b1;
            pending.pop_front();
            if (send_calm > 0) begin
                send_calm--;
                send_gap = 0;
            end else begin
                if ($urandom_range(0, 49) == 0) send_calm = $urandom_range(30, 120);
                send_gap = pick_idle();
            end
        end else begin
            in_valid <= 1'b0;
        end
    end

    // result receiver, with an occasional long hold-off
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (results_seen >= hold_mark) begin
                hold_left = LONG_HOLD;
                hold_mark += 1000;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (recv_calm > 0) begin
                recv_calm--;
                out_ready <= 1'b1;
            end else begin
                if ($urandom_range(0, 49) == 0) recv_calm = $urandom_range(30, 120);
                stall_left = pick_idle();
                if (stall_left == 0) begin
                    out_ready <= 1'b1;
                end else begin
                    stall_left--;
                    out_ready <= 1'b0;
                end
            end
        end
    end

    // handshake monitor, result check and watchdog
    always @(posedge clk) begin
        in_taken = in_valid && in_ready;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                results_seen++;
                if (awaited.size() == 0) begin
                    if (errors < 10) $display("unexpected result: %s", show(out_data));
                    errors++;
                end else begin
                    want = awaited.pop_front();
                    if (out_data.out_key !== want.out_key ||
                        out_data.out_value !== want.out_value ||
                        out_data.is_last !== want.is_last ||
                        out_data.status !== want.status ||
                        out_data.overflowed !== want.overflowed) begin
                        if (errors < 10)
                            $display("result %0d mismatch: expected %s, got %s",
                                     results_seen, show(want), show(out_data));
                        errors++;
                    end
                end
            end
            if (in_taken) sort_predict(in_data);
            if (in_taken || (out_valid && out_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout after %0d quiet cycles", idle_cycles);
                $display("[stable_counting_sort] ERROR");
                $finish;
            end
        end
    end

endmodule
